// ===== rtl/pfan_pkg.sv =====
// Shared types and constants for the palette find-or-add block.
package pfan_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_NEAR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OUT_MATCH  = 2'd0,
        OUT_APPEND = 2'd1,
        OUT_NEAR   = 2'd2,
        OUT_CLEAR  = 2'd3
    } t_outcome;

    localparam logic OP_FIND  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam int RGB_W  = 48;
    localparam int SQ_W   = 32;
    localparam int DIST_W = 34;

    localparam logic [RGB_W-1:0]  WHITE_RGB  = {RGB_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_START = 34'h3_0000_0000;

endpackage

// ===== rtl/palette_find_or_add_nearest.sv =====
// Palette builder: exact-match lookup, append, and nearest-color fallback.
//
// Issue a transaction by raising start while busy is low. A clear finishes
// in the cycle after it is accepted. A find-or-add scans entries 1 to
// fill_count-1 through the single read port of the palette memory, one
// entry per cycle; when the palette is full and no entry matches exactly, a
// second scan through the squared-distance pipeline follows. The result
// is shown for exactly one cycle with o_valid and cannot be held off; a new
// transaction may be issued in that same cycle.
module palette_find_or_add_nearest #(
    parameter int PALETTE_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [15:0] i_red,
    input  logic [15:0] i_green,
    input  logic [15:0] i_blue,
    input  logic        i_glow,
    input  logic        i_update_glow,
    output logic        o_valid,
    output logic [7:0]  o_color_index,
    output logic [1:0]  o_outcome,
    output logic [8:0]  o_entries_used
);
    import pfan_pkg::*;

    localparam int IW = $clog2(PALETTE_SIZE);
    localparam int CW = $clog2(PALETTE_SIZE + 1);

    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d;
    endfunction

    logic [RGB_W-1:0] mem_rgb  [PALETTE_SIZE];
    logic             mem_glow [PALETTE_SIZE];

    t_state            r_state, n_state;
    logic [CW-1:0]     r_fill, n_fill;
    logic [CW-1:0]     r_addr, n_addr;
    logic [IW-1:0]     r_idx, n_idx;
    t_outcome          r_outcome, n_outcome;
    logic [DIST_W-1:0] r_best, n_best;
    logic [RGB_W-1:0]  r_key, n_key;
    logic              r_glow, n_glow;
    logic              r_upd, n_upd;

    logic [RGB_W-1:0]  r_mem_q;
    logic              r_p1_vld;
    logic [IW-1:0]     r_p1_idx;
    logic              r_p2_vld;
    logic [IW-1:0]     r_p2_idx;
    logic [SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;

    logic              issue;
    logic              rgb_we;
    logic              glow_we;
    logic [IW-1:0]     w_addr;
    logic [RGB_W-1:0]  w_rgb;
    logic              w_glow;
    logic [DIST_W-1:0] sum_sq;
    logic [15:0]       d_r, d_g, d_b;
    logic [IW+7:0]     idx_ext;
    logic [CW+8:0]     fill_ext;

    assign sum_sq = {2'b00, r_sq_r} + {2'b00, r_sq_g} + {2'b00, r_sq_b};
    assign d_r  = abs_diff(r_key[47:32], r_mem_q[47:32]);
    assign d_g  = abs_diff(r_key[31:16], r_mem_q[31:16]);
    assign d_b  = abs_diff(r_key[15:0],  r_mem_q[15:0]);

    always_ff @(posedge i_clk) begin
        if (rgb_we) begin
            mem_rgb[w_addr] <= w_rgb;
        end
        r_mem_q <= mem_rgb[r_addr[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (glow_we) begin
            mem_glow[w_addr] <= w_glow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_idx <= r_addr[IW-1:0];
        r_p2_idx <= r_p1_idx;
        r_sq_r   <= SQ_W'(d_r) * SQ_W'(d_r);
        r_sq_g   <= SQ_W'(d_g) * SQ_W'(d_g);
        r_sq_b   <= SQ_W'(d_b) * SQ_W'(d_b);
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld && (r_state == S_NEAR);
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_idx     <= n_idx;
        r_outcome <= n_outcome;
        r_best    <= n_best;
        r_key     <= n_key;
        r_glow    <= n_glow;
        r_upd     <= n_upd;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= CW'(1);
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_addr    = r_addr;
        n_idx     = r_idx;
        n_outcome = r_outcome;
        n_best    = r_best;
        n_key     = r_key;
        n_glow    = r_glow;
        n_upd     = r_upd;
        issue     = 1'b0;
        rgb_we    = 1'b0;
        glow_we   = 1'b0;
        w_addr    = r_fill[IW-1:0];
        w_rgb     = r_key;
        w_glow    = r_glow;
        unique case (r_state)
            S_IDLE, S_DONE: begin
                n_state = S_IDLE;
                if (start) begin
                    n_key  = {i_red, i_green, i_blue};
                    n_glow = i_glow;
                    n_upd  = i_update_glow;
                    n_addr = CW'(1);
                    if (i_operation == OP_CLEAR) begin
                        rgb_we    = 1'b1;
                        glow_we   = 1'b1;
                        w_addr    = '0;
                        w_rgb     = WHITE_RGB;
                        w_glow    = 1'b0;
                        n_fill    = CW'(1);
                        n_idx     = '0;
                        n_outcome = OUT_CLEAR;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                issue = (r_addr < r_fill);
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                priority if (r_p1_vld && (r_mem_q == r_key)) begin
                    n_idx     = r_p1_idx;
                    n_outcome = OUT_MATCH;
                    glow_we   = r_upd;
                    w_addr    = r_p1_idx;
                    n_state   = S_DONE;
                end else if (!issue && !r_p1_vld) begin
                    if (r_fill < CW'(PALETTE_SIZE)) begin
                        rgb_we    = 1'b1;
                        glow_we   = 1'b1;
                        n_idx     = r_fill[IW-1:0];
                        n_fill    = r_fill + 1'b1;
                        n_outcome = OUT_APPEND;
                        n_state   = S_DONE;
                    end else begin
                        n_addr  = CW'(1);
                        n_best  = DIST_START;
                        n_idx   = '0;
                        n_state = S_NEAR;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_NEAR: begin
                issue = (r_addr < r_fill);
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_p2_vld && (sum_sq < r_best)) begin
                    n_best = sum_sq;
                    n_idx  = r_p2_idx;
                end
                if (!issue && !r_p1_vld && !r_p2_vld) begin
                    n_outcome = OUT_NEAR;
                    n_state   = S_DONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign idx_ext        = {8'b0, r_idx};
    assign fill_ext       = {9'b0, r_fill};
    assign busy           = (r_state == S_SCAN) || (r_state == S_NEAR);
    assign o_valid        = (r_state == S_DONE);
    assign o_color_index  = idx_ext[7:0];
    assign o_outcome      = r_outcome;
    assign o_entries_used = fill_ext[8:0];

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome == OUT_CLEAR)) |-> (r_idx == '0) && (r_fill == CW'(1)))
        else $error("clear result does not show the reserved entry alone");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome == OUT_APPEND)) |->
            (r_fill == $past(r_fill) + 1'b1) && (r_idx == $past(r_fill[IW-1:0])))
        else $error("append did not take the next free entry");

    a_near_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEAR) |-> (r_fill == CW'(PALETTE_SIZE)))
        else $error("nearest search entered with room left in the palette");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != '0) && (r_fill <= CW'(PALETTE_SIZE)))
        else $error("fill count out of range");

endmodule
